@@ design/gwm_pkg.sv @@
// Package for the glob wildcard matcher: function codes, queue command type,
// special pattern bytes and default sizes. No dependencies.
`default_nettype none

package gwm_pkg;

    localparam int MAX_PATTERN_DEF = 32;
    localparam int Q_DEPTH         = 2;

    localparam logic [7:0] STAR_CODE  = 8'h2A;
    localparam logic [7:0] QMARK_CODE = 8'h3F;

    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_APPEND = 2'd1;
    localparam logic [1:0] FUNC_SOURCE = 2'd2;
    localparam logic [1:0] FUNC_END    = 2'd3;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_APPEND,
        OP_SOURCE,
        OP_END
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] code;
        logic       is_star;
        logic       is_qmark;
    } cmd_t;

endpackage

`default_nettype wire

@@ design/gwm_if.sv @@
// Handshake channels of the glob wildcard matcher: request items in,
// verdict items out. Standalone, no package needed.
`default_nettype none

interface gwm_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] char_code;

    modport source (output valid, output func, output char_code, input ready);
    modport sink   (input valid, input func, input char_code, output ready);
endinterface

interface gwm_rsp_if;
    logic valid;
    logic ready;
    logic matched;
    logic pattern_overflow;

    modport source (output valid, output matched, output pattern_overflow, input ready);
    modport sink   (input valid, input matched, input pattern_overflow, output ready);
endinterface

`default_nettype wire

@@ design/glob_wildcard_match.sv @@
// Top level of the glob wildcard matcher: front decode, command queue and
// matching back end. Depends on gwm_pkg, gwm_if, gwm_front, gwm_queue, gwm_back.
`default_nettype none

// Load a pattern with append items ('*' any run, '?' one byte), then stream
// source bytes and send an end item to get one verdict item: matched plus a
// flag telling that appends beyond MAX_PATTERN were dropped. Clear and append
// restart any match in progress; end keeps the pattern and restarts the match.
// The back end takes one item per clock while no end item waits on an untaken
// verdict; the set of reachable pattern positions is updated in parallel
// with a single carry chain of MAX_PATTERN+1 bits. A two-entry queue sits
// between decode and the back end, and an end item waits there only while the
// previous verdict sits in the output register untaken. Each request is
// registered in the queue before the back end registers its verdict.
module glob_wildcard_match
    import gwm_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
)
(
    input  wire       clk,
    input  wire       rst_n,
    gwm_req_if.sink   req,
    gwm_rsp_if.source rsp
);

    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_cmd;

    gwm_front u_front
    (
        .req        (req),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready)
    );

    gwm_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_cmd    (pop_cmd),
        .pop_ready  (pop_ready)
    );

    gwm_back #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_cmd   (pop_cmd),
        .pop_ready (pop_ready),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

@@ design/gwm_front.sv @@
// Front end: accepts request items, decodes the function and classifies the
// character as star or question mark. Depends on gwm_pkg and gwm_if.
`default_nettype none

module gwm_front
    import gwm_pkg::*;
(
    gwm_req_if.sink req,
    output logic    push_valid,
    output cmd_t    push_cmd,
    input  logic    push_ready
);

    always_comb
    begin
        push_cmd.code     = req.char_code;
        push_cmd.is_star  = (req.char_code == STAR_CODE);
        push_cmd.is_qmark = (req.char_code == QMARK_CODE);
        unique case (req.func)
            FUNC_CLEAR:  push_cmd.op = OP_CLEAR;
            FUNC_APPEND: push_cmd.op = OP_APPEND;
            FUNC_SOURCE: push_cmd.op = OP_SOURCE;
            FUNC_END:    push_cmd.op = OP_END;
            default:     push_cmd.op = OP_END;
        endcase
    end

    assign push_valid = req.valid;
    assign req.ready  = push_ready;

endmodule

`default_nettype wire

@@ design/gwm_queue.sv @@
// Short command queue between front and back end so each side stalls on its
// own. Depends on gwm_pkg.
`default_nettype none

module gwm_queue
    import gwm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    input  cmd_t push_cmd,
    output logic push_ready,
    output logic pop_valid,
    output cmd_t pop_cmd,
    input  logic pop_ready
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    cmd_t             mem [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ design/gwm_back.sv @@
// Back end: holds the pattern, updates the active position set bit-parallel,
// and registers the verdict. Depends on gwm_pkg and gwm_if.
`default_nettype none

module gwm_back
    import gwm_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pop_valid,
    input  cmd_t      pop_cmd,
    output logic      pop_ready,
    gwm_rsp_if.source rsp
);

    localparam int W     = MAX_PATTERN;
    localparam int AW    = MAX_PATTERN + 1;
    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W = (W > 1) ? $clog2(W) : 1;

    // Pattern cells; each is compared in place, only the write index varies.
    logic [7:0]       char_reg [W];
    logic [W-1:0]     star_reg;
    logic [W-1:0]     qmark_reg;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             ovf_reg, ovf_next;
    logic [AW-1:0]    active_reg, active_next;
    // Restart set: position zero plus the run of leading stars.
    logic [AW-1:0]    rst_vec_reg, rst_vec_next;
    logic             lead_star_reg, lead_star_next;

    logic             out_valid_reg, out_valid_next;
    logic             matched_reg;
    logic             out_ovf_reg;

    logic [W-1:0]     in_pat;
    logic [W-1:0]     star_m;
    logic [W-1:0]     match_m;
    logic [AW-1:0]    stepped;
    logic [AW-1:0]    prop_a;
    logic [AW-1:0]    prop_b;
    logic [AW-1:0]    prop_sum;
    logic [AW-1:0]    closed;
    logic             do_pop;
    logic             do_append;
    logic             room;

    always_comb
    begin
        for (int p = 0; p < W; p++)
        begin
            in_pat[p]  = (LEN_W'(p) < len_reg);
            star_m[p]  = in_pat[p] && star_reg[p];
            match_m[p] = in_pat[p] && !star_reg[p]
                         && (qmark_reg[p] || (char_reg[p] == pop_cmd.code));
        end
    end

    // Stars hold their position, matches move one up; then close over star
    // runs with a carry chain (generate = active star, propagate = star).
    always_comb
    begin
        stepped  = {1'b0, active_reg[W-1:0] & star_m}
                 | {active_reg[W-1:0] & match_m, 1'b0};
        prop_a   = {1'b0, star_m};
        prop_b   = stepped & prop_a;
        prop_sum = prop_a + prop_b;
        closed   = stepped | (prop_sum ^ prop_a ^ prop_b);
    end

    assign pop_ready = (pop_cmd.op != OP_END) || !out_valid_reg || rsp.ready;
    assign do_pop    = pop_valid && pop_ready;
    assign room      = (len_reg < LEN_W'(MAX_PATTERN));
    assign do_append = do_pop && (pop_cmd.op == OP_APPEND) && room;

    always_comb
    begin
        len_next       = len_reg;
        ovf_next       = ovf_reg;
        active_next    = active_reg;
        rst_vec_next   = rst_vec_reg;
        lead_star_next = lead_star_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        if (do_pop)
        begin
            unique case (pop_cmd.op)
                OP_CLEAR:
                begin
                    len_next       = '0;
                    ovf_next       = 1'b0;
                    rst_vec_next   = AW'(1);
                    lead_star_next = 1'b1;
                    active_next    = AW'(1);
                end
                OP_APPEND:
                begin
                    if (room)
                    begin
                        len_next = len_reg + 1'b1;
                        if (lead_star_reg && pop_cmd.is_star)
                        begin
                            rst_vec_next = rst_vec_reg | (AW'(1) << (len_reg + 1'b1));
                        end
                        else
                        begin
                            lead_star_next = 1'b0;
                        end
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    active_next = rst_vec_next;
                end
                OP_SOURCE:
                begin
                    active_next = closed;
                end
                OP_END:
                begin
                    out_valid_next = 1'b1;
                    active_next    = rst_vec_reg;
                end
                default:
                begin
                    active_next = active_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_append)
        begin
            char_reg[len_reg[IDX_W-1:0]]  <= pop_cmd.code;
            star_reg[len_reg[IDX_W-1:0]]  <= pop_cmd.is_star;
            qmark_reg[len_reg[IDX_W-1:0]] <= pop_cmd.is_qmark;
        end
        if (do_pop && (pop_cmd.op == OP_END))
        begin
            matched_reg <= active_reg[len_reg];
            out_ovf_reg <= ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            active_reg    <= AW'(1);
            rst_vec_reg   <= AW'(1);
            lead_star_reg <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            active_reg    <= active_next;
            rst_vec_reg   <= rst_vec_next;
            lead_star_reg <= lead_star_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.matched          = matched_reg;
    assign rsp.pattern_overflow = out_ovf_reg;

endmodule

`default_nettype wire

@@ bench/tb_glob_wildcard_match.sv @@
`timescale 1ns / 1ps
// Self-checking bench for glob_wildcard_match: predicts each verdict item from a
// shadow of the pattern and the reachable positions. Uses gwm_pkg, gwm_req_if and gwm_rsp_if.

module tb_glob_wildcard_match;
    import gwm_pkg::*;

    localparam int MAX_PAT          = MAX_PATTERN_DEF;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int HOLD_CYCLES      = 300;
    localparam int RANDOM_PER_PHASE = 190;
    localparam logic [7:0] LETTER_A = 8'h61;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] code;
    } req_item_t;

    typedef struct packed {
        logic matched;
        logic overflow;
    } verdict_t;

    logic clk;
    logic rst_n;

    gwm_req_if req();
    gwm_rsp_if rsp();

    glob_wildcard_match dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    req_item_t  req_backlog[$];
    verdict_t   verdicts_due[$];
    logic [7:0] gen_pattern[$];   // pattern as the generator sees it, for shaping sources

    int idle_pct;
    int stall_pct;
    int hold_reqs;
    int hold_seen;
    int hold_left;
    int queued_items;
    int items_taken;
    int verdicts_seen;
    int match_seen;
    int overflow_seen;
    int error_count;
    int cycle_cnt;

    // shadow of the matcher
    logic [7:0]       pat_bytes [MAX_PAT];
    int               pat_len;
    logic             pat_overflow;
    logic [MAX_PAT:0] reach;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [MAX_PAT:0] star_closure(input logic [MAX_PAT:0] s);
        logic [MAX_PAT:0] r;
        r = s;
        for (int p = 0; p < pat_len; p++)
            if (r[p] && pat_bytes[p] == STAR_CODE)
                r[p + 1] = 1'b1;
        return r;
    endfunction

    function automatic void track_match(input logic [1:0] func, input logic [7:0] code);
        logic [MAX_PAT:0] nxt;
        nxt = '0;
        case (func)
            FUNC_CLEAR:
            begin
                pat_len      = 0;
                pat_overflow = 1'b0;
                reach        = star_closure((MAX_PAT + 1)'(1));
            end
            FUNC_APPEND:
            begin
                if (pat_len < MAX_PAT)
                begin
                    pat_bytes[pat_len] = code;
                    pat_len++;
                end
                else
                    pat_overflow = 1'b1;
                reach = star_closure((MAX_PAT + 1)'(1));
            end
            FUNC_SOURCE:
            begin
                for (int p = 0; p < pat_len; p++)
                begin
                    if (reach[p])
                    begin
                        if (pat_bytes[p] == STAR_CODE)
                            nxt[p] = 1'b1;
                        else if (pat_bytes[p] == QMARK_CODE || pat_bytes[p] == code)
                            nxt[p + 1] = 1'b1;
                    end
                end
                reach = star_closure(nxt);
            end
            default:
            begin
                verdicts_due.insert(verdicts_due.size(),
                                    verdict_t'{matched: reach[pat_len], overflow: pat_overflow});
                reach = star_closure((MAX_PAT + 1)'(1));
            end
        endcase
    endfunction

    function automatic void check_verdict(input logic matched, input logic overflow);
        verdict_t want;
        if (verdicts_due.size() == 0)
        begin
            error_count++;
            $display("%0t: unexpected verdict matched=%b overflow=%b", $time, matched, overflow);
        end
        else
        begin
            want = verdicts_due.pop_front();
            verdicts_seen++;
            if (want.matched)
                match_seen++;
            if (want.overflow)
                overflow_seen++;
            if (matched !== want.matched)
            begin
                error_count++;
                $display("%0t: matched expected %b actual %b", $time, want.matched, matched);
            end
            if (overflow !== want.overflow)
            begin
                error_count++;
                $display("%0t: pattern_overflow expected %b actual %b",
                         $time, want.overflow, overflow);
            end
        end
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid     <= 1'b0;
            req.func      <= FUNC_CLEAR;
            req.char_code <= '0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                track_match(req.func, req.char_code);
                items_taken++;
            end
            if (!req.valid || req.ready)
            begin
                if (req_backlog.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    req.valid     <= 1'b1;
                    req.func      <= req_backlog[0].func;
                    req.char_code <= req_backlog[0].code;
                    void'(req_backlog.pop_front());
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    // verdict monitor and output back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
        begin
            if (rsp.valid && rsp.ready)
                check_verdict(rsp.matched, rsp.pattern_overflow);
            if (hold_seen != hold_reqs)
            begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic logic [7:0] pick_pattern_byte();
        int r;
        r = $urandom_range(9);
        if (r <= 2)
            return STAR_CODE;
        if (r <= 4)
            return QMARK_CODE;
        if (r <= 8)
            return LETTER_A + 8'($urandom_range(2));
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] pick_source_byte();
        int r;
        r = $urandom_range(9);
        if (r <= 6)
            return LETTER_A + 8'($urandom_range(2));
        if (r == 7)
            return $urandom_range(1) ? STAR_CODE : QMARK_CODE;
        return 8'($urandom_range(255));
    endfunction

    function automatic void push_item(input logic [1:0] func, input logic [7:0] code);
        req_backlog.insert(req_backlog.size(), req_item_t'{func: func, code: code});
        queued_items++;
        if (func == FUNC_CLEAR)
            gen_pattern.delete();
        else if (func == FUNC_APPEND && gen_pattern.size() < MAX_PAT)
            gen_pattern.insert(gen_pattern.size(), code);
    endfunction

    task automatic add_directed();
        push_item(FUNC_END, 8'h00);          // empty pattern, empty source
        push_item(FUNC_SOURCE, 8'h78);
        push_item(FUNC_END, 8'hFF);
        push_item(FUNC_APPEND, STAR_CODE);   // stars only, empty source
        push_item(FUNC_END, 8'h00);
        push_item(FUNC_CLEAR, 8'hFF);
        push_item(FUNC_APPEND, LETTER_A);
        push_item(FUNC_APPEND, QMARK_CODE);
        push_item(FUNC_APPEND, STAR_CODE);
        push_item(FUNC_SOURCE, LETTER_A);
        push_item(FUNC_SOURCE, 8'hFF);
        push_item(FUNC_SOURCE, 8'h00);
        push_item(FUNC_END, 8'h00);
        push_item(FUNC_END, 8'h00);          // empty source against a?*
        push_item(FUNC_CLEAR, 8'h00);
        push_item(FUNC_APPEND, 8'h00);       // zero byte is an ordinary char
        push_item(FUNC_SOURCE, 8'h00);
        push_item(FUNC_END, 8'h00);
        push_item(FUNC_SOURCE, 8'h01);       // append mid-source restarts the match
        push_item(FUNC_APPEND, LETTER_A + 8'd1);
        push_item(FUNC_SOURCE, 8'h00);
        push_item(FUNC_SOURCE, LETTER_A + 8'd1);
        push_item(FUNC_END, 8'h00);
    endtask

    // one pattern, then a few sources built to match it, some of them mutated
    task automatic add_pattern_sequence(input bit long_pat);
        int         len;
        int         n_src;
        int         r;
        logic [7:0] src[$];
        if (long_pat || $urandom_range(9) != 0)
            push_item(FUNC_CLEAR, 8'($urandom_range(255)));
        if (long_pat)
            len = MAX_PAT + 3;
        else if ($urandom_range(14) == 0)
            len = $urandom_range(MAX_PAT - 4, MAX_PAT + 6);
        else
            len = $urandom_range(0, 6);
        for (int i = 0; i < len; i++)
            push_item(FUNC_APPEND, pick_pattern_byte());
        n_src = $urandom_range(1, 4);
        for (int s = 0; s < n_src; s++)
        begin
            src.delete();
            foreach (gen_pattern[i])
            begin
                if (gen_pattern[i] == STAR_CODE)
                    repeat ($urandom_range(0, 2)) src.insert(src.size(), pick_source_byte());
                else if (gen_pattern[i] == QMARK_CODE)
                    src.insert(src.size(), pick_source_byte());
                else
                    src.insert(src.size(), gen_pattern[i]);
            end
            r = $urandom_range(5);
            if (r == 0 && src.size() != 0)
                src.delete($urandom_range(src.size() - 1));
            else if (r == 1)
                src.insert($urandom_range(src.size()), pick_source_byte());
            else if (r == 2 && src.size() != 0)
                src[$urandom_range(src.size() - 1)] = pick_source_byte();
            foreach (src[i])
                push_item(FUNC_SOURCE, src[i]);
            push_item(FUNC_END, 8'($urandom_range(255)));
        end
        if ($urandom_range(7) == 0)
            repeat ($urandom_range(1, 3))
                push_item(2'($urandom_range(3)), 8'($urandom_range(255)));
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (req_backlog.size() != 0 || req.valid || verdicts_due.size() != 0);
    endtask

    task automatic run_random_phase(input int idle, input int stall, input bit long_first);
        int target;
        idle_pct  = idle;
        stall_pct = stall;
        target    = queued_items + RANDOM_PER_PHASE;
        if (long_first)
            add_pattern_sequence(1'b1);
        while (queued_items < target)
            add_pattern_sequence(1'b0);
        drain();
    endtask

    // output held off while ends keep coming, so the input side must stall
    task automatic run_pressure();
        idle_pct  = 0;
        stall_pct = 0;
        hold_reqs++;
        add_pattern_sequence(1'b0);
        repeat (48)
        begin
            if ($urandom_range(1))
                push_item(FUNC_END, 8'($urandom_range(255)));
            else
                push_item(FUNC_SOURCE, pick_source_byte());
        end
        drain();
    endtask

    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("tb_glob_wildcard_match: done, errors");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        req.valid     = 1'b0;
        req.func      = FUNC_CLEAR;
        req.char_code = '0;
        rsp.ready     = 1'b0;
        idle_pct      = 0;
        stall_pct     = 0;
        pat_len       = 0;
        pat_overflow  = 1'b0;
        reach         = (MAX_PAT + 1)'(1);
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        add_directed();
        drain();
        run_random_phase(0, 0, 1'b1);
        run_random_phase(69, 0, 1'b0);
        run_random_phase(0, 69, 1'b1);
        run_random_phase(7, 7, 1'b0);
        run_pressure();
        repeat (10) @(posedge clk);

        $display("Sent %0d items over directed cases, four idle mixes and a long output hold",
                 items_taken);
        $display("Checked %0d verdicts: %0d matches, %0d with overflow, %0d mismatches",
                 verdicts_seen, match_seen, overflow_seen, error_count);
        if (error_count == 0)
            $display("tb_glob_wildcard_match: done, clean");
        else
            $display("tb_glob_wildcard_match: done, errors");
        $finish;
    end

endmodule
